// ===== design/rss_pkg.sv =====
`default_nettype none
package rss_pkg;

  localparam int unsigned CountW = 11;
  localparam int unsigned SumW   = 26;
  localparam int unsigned MagLW  = 26;
  localparam int unsigned MagRW  = 27;
  localparam int unsigned SqW    = 53;
  localparam int unsigned ScoreW = 41;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CountMax = 2047;

  localparam logic [0:0] RegSampleCount = 1'b0;
  localparam logic [0:0] RegTargetTotal = 1'b1;

  // One classified sample handed from the front end to the scoring engine.
  typedef struct packed {
    logic              scored;
    logic              last;
    logic [CountW-1:0] idx;
    logic [CountW-1:0] den;
    logic [MagLW-1:0]  mag_l;
    logic [MagRW-1:0]  mag_r;
  } entry_t;

endpackage
`default_nettype wire

// ===== design/regression_split_scan.sv =====
// A scored word goes through the square, start, divide and update states; it waits
// in divide on the 53-bit bit-serial dividers. An unscored word is handled on pop.
// One word is handled at a time; a four-word queue lets input run ahead.
// The result is registered once the output is free after the last word is handled.
// Reset (rst, synchronous) clears the run state, queue and output; no clearing pass.
`default_nettype none
module regression_split_scan #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [25:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] target_value
  input  wire logic        s_tlast,   // last_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [9:0] best_index, [50:10] best_score
  output logic             m_tuser    // split_found
);

  logic [rss_pkg::CountW-1:0] sample_count;
  logic [rss_pkg::SumW-1:0]   target_total;
  rss_pkg::entry_t front_entry, head;
  logic full, avail, pop, take;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= rss_pkg::CountW'(2);
      target_total <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rss_pkg::RegSampleCount: sample_count <= cfg_data[rss_pkg::CountW-1:0];
        rss_pkg::RegTargetTotal: target_total <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  rss_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst, .take, .target_value($signed(s_tdata)), .last_sample(s_tlast),
    .sample_count, .target_total, .entry(front_entry));

  rss_fifo u_fifo (.clk, .rst, .push(take), .wr_entry(front_entry), .full,
                   .pop, .not_empty(avail), .rd_entry(head));

  rss_back u_back (.clk, .rst, .avail, .head, .pop, .m_tvalid, .m_tready,
                   .m_tdata, .m_tuser);

  a_found_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == m_tdata[50]) else $error("found flag disagrees with score");
  a_index_none: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tdata[9:0] == '0) else $error("index without split");
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("result after reset");

endmodule
`default_nettype wire

// ===== design/rss_front.sv =====
`default_nettype none
module rss_front #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic signed [15:0]          target_value,
  input  wire logic                        last_sample,
  input  wire logic [rss_pkg::CountW-1:0]  sample_count,
  input  wire logic [rss_pkg::SumW-1:0]    target_total,
  output rss_pkg::entry_t                  entry
);

  localparam int unsigned NCap = (MAX_SAMPLES > rss_pkg::CountMax) ?
                                 rss_pkg::CountMax : MAX_SAMPLES;

  logic [rss_pkg::CountW-1:0] seen_count, seen_count_next;
  logic [rss_pkg::SumW-1:0]   prefix_sum, prefix_sum_next;
  logic [rss_pkg::CountW-1:0] n_eff;
  logic signed [rss_pkg::SumW:0] sr;
  logic [rss_pkg::SumW-1:0]   sl_abs;
  logic [rss_pkg::SumW:0]     sr_abs;

  always_comb begin
    n_eff = (sample_count > rss_pkg::CountW'(NCap)) ? rss_pkg::CountW'(NCap) : sample_count;
    seen_count_next = (seen_count == rss_pkg::CountW'(rss_pkg::CountMax)) ?
                      seen_count : seen_count + 1'b1;
    prefix_sum_next = prefix_sum + rss_pkg::SumW'(target_value);
    sr = $signed({target_total[rss_pkg::SumW-1], target_total})
       - $signed({prefix_sum_next[rss_pkg::SumW-1], prefix_sum_next});
    sl_abs = prefix_sum_next[rss_pkg::SumW-1] ? (~prefix_sum_next + 1'b1) : prefix_sum_next;
    sr_abs = sr[rss_pkg::SumW] ? (~sr + 1'b1) : sr;
    entry.scored = seen_count_next < n_eff;
    entry.last   = last_sample;
    entry.idx    = seen_count_next;
    entry.den    = n_eff - seen_count_next;
    entry.mag_l  = sl_abs;
    entry.mag_r  = sr_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
      prefix_sum <= '0;
    end else if (take) begin
      if (last_sample) begin
        seen_count <= '0;
        prefix_sum <= '0;
      end else begin
        seen_count <= seen_count_next;
        prefix_sum <= prefix_sum_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/rss_fifo.sv =====
`default_nettype none
module rss_fifo (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  rss_pkg::entry_t wr_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output rss_pkg::entry_t rd_entry
);

  rss_pkg::entry_t slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;

  assign full      = fill == 3'd4;
  assign not_empty = fill != 3'd0;
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + {2'b00, push} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/rss_div.sv =====
`default_nettype none
module rss_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rss_pkg::SqW-1:0]     dividend,
  input  wire logic [rss_pkg::CountW-1:0]  divisor,
  output logic                             done,
  output logic [rss_pkg::SqW-1:0]          quotient
);

  localparam int unsigned CntW = $clog2(rss_pkg::SqW);

  logic                       busy;
  logic [CntW-1:0]            cnt;
  logic [rss_pkg::CountW-1:0] rem;
  logic [rss_pkg::CountW-1:0] dvs;
  logic [rss_pkg::CountW:0]   trial;
  logic                       fits;

  always_comb begin
    trial = {rem, quotient[rss_pkg::SqW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Restoring division, one quotient bit per cycle; quotient holds the
  // remaining dividend bits until they are shifted out.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[rss_pkg::SqW-2:0], fits};
      rem      <= fits ? rss_pkg::CountW'(trial - {1'b0, dvs}) : trial[rss_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == '0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(rss_pkg::SqW - 1);
      end else if (busy) begin
        if (cnt == '0) busy <= 1'b0;
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/rss_back.sv =====
`default_nettype none
module rss_back (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    avail,
  input  rss_pkg::entry_t head,
  output logic         pop,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output logic [55:0]  m_tdata,
  output logic         m_tuser
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_GO   = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_UPD  = 5'b10000
  } state_t;

  state_t state;
  logic   emit_pend;
  rss_pkg::entry_t cur;
  logic [rss_pkg::SqW-1:0] sq_l, sq_r, q_l, q_r;
  logic done_l, done_r, start;
  logic signed [rss_pkg::ScoreW-1:0] lowest_score, score;
  logic [rss_pkg::IndexW-1:0] lowest_index;
  logic [rss_pkg::SqW:0] msum, msat;
  logic out_free;

  localparam logic [rss_pkg::SqW:0] Limit = (rss_pkg::SqW+1)'(1) << 40;

  assign out_free = !m_tvalid || m_tready;
  assign start    = state == ST_GO;
  assign pop      = state == ST_IDLE && !emit_pend && avail;

  always_comb begin
    msum  = {1'b0, q_l} + {1'b0, q_r};
    msat  = (msum > Limit) ? Limit : msum;
    score = -$signed(msat[rss_pkg::ScoreW-1:0]);
  end

  rss_div u_div_l (.clk, .rst, .start, .dividend(sq_l), .divisor(cur.idx),
                   .done(done_l), .quotient(q_l));
  rss_div u_div_r (.clk, .rst, .start, .dividend(sq_r), .divisor(cur.den),
                   .done(done_r), .quotient(q_r));

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (state == ST_SQ) begin
      sq_l <= rss_pkg::SqW'(cur.mag_l * cur.mag_l);
      sq_r <= rss_pkg::SqW'(cur.mag_r * cur.mag_r);
    end
    if (out_free && emit_pend) begin
      m_tdata <= {5'b0, lowest_score, lowest_index};
      m_tuser <= lowest_score < 0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      emit_pend    <= 1'b0;
      m_tvalid     <= 1'b0;
      lowest_score <= '0;
      lowest_index <= '0;
    end else begin
      if (out_free) m_tvalid <= emit_pend;
      if (out_free && emit_pend) begin
        emit_pend    <= 1'b0;
        lowest_score <= '0;
        lowest_index <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head.scored) state <= ST_SQ;
            else emit_pend <= head.last;
          end
        end
        ST_SQ:  state <= ST_GO;
        ST_GO:  state <= ST_DIV;
        ST_DIV: if (done_l && done_r) state <= ST_UPD;
        ST_UPD: begin
          if (score < lowest_score) begin
            lowest_score <= score;
            lowest_index <= cur.idx[rss_pkg::IndexW-1:0];
          end
          emit_pend <= cur.last;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
